>>> rtl/ptwa_pkg.sv
// Shared codes for the peer table: action codes, result kinds and
// configuration register indexes. No dependencies.
package ptwa_pkg;

    typedef enum logic [1:0] {
        ACT_TOUCH  = 2'd0,
        ACT_DROP   = 2'd1,
        ACT_EXPIRE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_TOUCH   = 2'd0,
        KIND_DROP    = 2'd1,
        KIND_EXPIRED = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // register index as decoded from paddr[2]
    localparam logic REG_STALE_LIMIT = 1'b0;

    localparam logic [31:0] STALE_LIMIT_RESET = 32'd90000;

endpackage

>>> rtl/peer_table_with_aging.sv
// Peer table with aging: name-keyed neighbor table in one entry memory,
// plus a name buffer for expire reports. Depends on ptwa_pkg.
//
// Usage: an item (action plus payload) is transferred at a rising edge with
// start high and busy low. Results come out one per cycle, each marked by
// result_valid for exactly one cycle; last flags the final result of the
// item. The receiver cannot stall; results are never held back.
// The table sits in a single-port-read synchronous memory and is scanned one
// entry per cycle. Touch and drop scan until the name is found or the entries
// run out; a drop hit then moves the last entry into the freed slot. Expire
// checks every entry, removing stale ones, then reports each removed name
// (or a single "none" result). Configuration (stale_limit_ms, byte address 0)
// goes over the APB port; the user must see that it is written only while
// the block is idle, as the block itself does not enforce this. Reset empties
// the table (count 0) and restores the stale limit to 90000 ms; no clearing
// pass is run.
module peer_table_with_aging #(
    parameter int TABLE_DEPTH = 64,
    parameter int NAME_BYTES  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [63:0] name_low,
    input  logic [63:0] name_high,
    input  logic [63:0] station_id,
    input  logic [31:0] peer_address,
    input  logic [15:0] peer_port,
    input  logic [47:0] now_ms,
    // result channel
    output logic        result_valid,
    output logic [1:0]  kind,
    output logic        is_new,
    output logic        table_full,
    output logic [63:0] out_name_low,
    output logic [63:0] out_name_high,
    output logic [6:0]  entry_count,
    output logic        last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int NAME_W = 8 * NAME_BYTES;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [63:0]       station;
        logic [47:0]       seen;
        logic [31:0]       addr;
        logic [15:0]       port;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_DROP_MOVE,
        ST_EXP_CHK,
        ST_EMIT
    } state_t;

    // memories
    entry_t            entry_mem [TABLE_DEPTH];
    logic [NAME_W-1:0] rbuf_mem  [TABLE_DEPTH];

    state_t            state_reg, state_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     nres_reg, nres_next;
    logic              move_reg, move_next;
    logic [1:0]        act_reg, act_next;
    logic [NAME_W-1:0] key_reg, key_next;
    logic [63:0]       station_reg, station_next;
    logic [31:0]       addr_reg, addr_next;
    logic [15:0]       port_reg, port_next;
    logic [47:0]       now_reg, now_next;
    logic [31:0]       limit_reg;

    logic              out_valid_reg, out_valid_next;
    ptwa_pkg::kind_t   kind_reg, kind_next;
    logic              is_new_reg, is_new_next;
    logic              full_reg, full_next;
    logic              last_reg, last_next;
    logic              name_sel_reg, name_sel_next;

    entry_t            ent_rd_reg;
    logic [NAME_W-1:0] rb_rd_reg;

    logic [AW-1:0]     ent_ra;
    logic              ent_we;
    logic [AW-1:0]     ent_wa;
    entry_t            ent_wd;
    logic              rb_we;
    logic [AW-1:0]     rb_wa;
    logic [AW-1:0]     rb_ra;

    logic [127:0]      name_in;
    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     cnt_dec;
    logic [CW-1:0]     cnt_inc;
    logic              in_range;
    logic              name_hit;
    logic              changed;
    logic [47:0]       age;
    logic              stale;
    entry_t            upd_entry;
    entry_t            new_entry;
    logic              cfg_write;

    assign name_in  = {name_high, name_low};
    assign idx_inc  = idx_reg + ONE_C;
    assign cnt_dec  = count_reg - ONE_C;
    assign cnt_inc  = count_reg + ONE_C;
    assign in_range = (idx_reg < count_reg);
    assign name_hit = (ent_rd_reg.name == key_reg);

    assign changed = (ent_rd_reg.station != station_reg)
                  || ((addr_reg != 32'd0) && (ent_rd_reg.addr != addr_reg))
                  || ((port_reg != 16'd0) && (ent_rd_reg.port != port_reg));

    // wrapping age against the limit
    assign age   = now_reg - ent_rd_reg.seen;
    assign stale = (age > {16'd0, limit_reg});

    always_comb
    begin
        upd_entry         = ent_rd_reg;
        upd_entry.station = station_reg;
        upd_entry.seen    = now_reg;
        if (addr_reg != 32'd0)
        begin
            upd_entry.addr = addr_reg;
        end
        if (port_reg != 16'd0)
        begin
            upd_entry.port = port_reg;
        end
        new_entry.name    = key_reg;
        new_entry.station = station_reg;
        new_entry.seen    = now_reg;
        new_entry.addr    = addr_reg;
        new_entry.port    = port_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        nres_next      = nres_reg;
        move_next      = move_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        station_next   = station_reg;
        addr_next      = addr_reg;
        port_next      = port_reg;
        now_next       = now_reg;
        out_valid_next = 1'b0;
        kind_next      = kind_reg;
        is_new_next    = is_new_reg;
        full_next      = full_reg;
        last_next      = last_reg;
        name_sel_next  = name_sel_reg;
        ent_ra         = '0;
        ent_we         = 1'b0;
        ent_wa         = idx_reg[AW-1:0];
        ent_wd         = upd_entry;
        rb_we          = 1'b0;
        rb_wa          = nres_reg[AW-1:0];
        rb_ra          = idx_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next     = action;
                    key_next     = name_in[NAME_W-1:0];
                    station_next = station_id;
                    addr_next    = peer_address;
                    port_next    = peer_port;
                    now_next     = now_ms;
                    idx_next     = '0;
                    nres_next    = '0;
                    move_next    = 1'b0;
                    unique case (action)
                        ptwa_pkg::ACT_TOUCH,
                        ptwa_pkg::ACT_DROP:   state_next = ST_FIND;
                        ptwa_pkg::ACT_EXPIRE: state_next = ST_EXP_CHK;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end

            ST_FIND:
            begin
                if (!in_range)
                begin
                    // miss
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    name_sel_next  = 1'b0;
                    is_new_next    = 1'b0;
                    full_next      = 1'b0;
                    state_next     = ST_IDLE;
                    if (act_reg == ptwa_pkg::ACT_TOUCH)
                    begin
                        kind_next = ptwa_pkg::KIND_TOUCH;
                        if (count_reg < DEPTH_C)
                        begin
                            ent_we      = 1'b1;
                            ent_wa      = count_reg[AW-1:0];
                            ent_wd      = new_entry;
                            count_next  = cnt_inc;
                            is_new_next = 1'b1;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                    end
                    else
                    begin
                        kind_next = ptwa_pkg::KIND_DROP;
                    end
                end
                else if (name_hit)
                begin
                    if (act_reg == ptwa_pkg::ACT_TOUCH)
                    begin
                        ent_we         = 1'b1;
                        ent_wd         = upd_entry;
                        out_valid_next = 1'b1;
                        kind_next      = ptwa_pkg::KIND_TOUCH;
                        is_new_next    = changed;
                        full_next      = 1'b0;
                        last_next      = 1'b1;
                        name_sel_next  = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        // fetch the last entry to fill the hole
                        ent_ra     = cnt_dec[AW-1:0];
                        state_next = ST_DROP_MOVE;
                    end
                end
                else
                begin
                    ent_ra   = idx_inc[AW-1:0];
                    idx_next = idx_inc;
                end
            end

            ST_DROP_MOVE:
            begin
                ent_we         = 1'b1;
                ent_wd         = ent_rd_reg;
                count_next     = cnt_dec;
                out_valid_next = 1'b1;
                kind_next      = ptwa_pkg::KIND_DROP;
                is_new_next    = 1'b0;
                full_next      = 1'b0;
                last_next      = 1'b1;
                name_sel_next  = 1'b0;
                state_next     = ST_IDLE;
            end

            ST_EXP_CHK:
            begin
                if (!in_range)
                begin
                    idx_next = '0;
                    if (nres_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = ptwa_pkg::KIND_NONE;
                        is_new_next    = 1'b0;
                        full_next      = 1'b0;
                        last_next      = 1'b1;
                        name_sel_next  = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    // slot idx holds the entry just read; after a move it
                    // still has to be written back there
                    ent_we = move_reg;
                    ent_wd = ent_rd_reg;
                    if (stale)
                    begin
                        rb_we      = 1'b1;
                        nres_next  = nres_reg + ONE_C;
                        count_next = cnt_dec;
                        ent_ra     = cnt_dec[AW-1:0];
                        move_next  = 1'b1;
                    end
                    else
                    begin
                        ent_ra    = idx_inc[AW-1:0];
                        idx_next  = idx_inc;
                        move_next = 1'b0;
                    end
                end
            end

            ST_EMIT:
            begin
                rb_ra          = idx_reg[AW-1:0];
                out_valid_next = 1'b1;
                kind_next      = ptwa_pkg::KIND_EXPIRED;
                is_new_next    = 1'b0;
                full_next      = 1'b0;
                name_sel_next  = 1'b1;
                last_next      = (idx_inc == nres_reg);
                idx_next       = idx_inc;
                if (idx_inc == nres_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            nres_reg      <= '0;
            move_reg      <= 1'b0;
            act_reg       <= '0;
            key_reg       <= '0;
            station_reg   <= '0;
            addr_reg      <= '0;
            port_reg      <= '0;
            now_reg       <= '0;
            limit_reg     <= ptwa_pkg::STALE_LIMIT_RESET;
            out_valid_reg <= 1'b0;
            kind_reg      <= ptwa_pkg::KIND_TOUCH;
            is_new_reg    <= 1'b0;
            full_reg      <= 1'b0;
            last_reg      <= 1'b0;
            name_sel_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            nres_reg      <= nres_next;
            move_reg      <= move_next;
            act_reg       <= act_next;
            key_reg       <= key_next;
            station_reg   <= station_next;
            addr_reg      <= addr_next;
            port_reg      <= port_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            is_new_reg    <= is_new_next;
            full_reg      <= full_next;
            last_reg      <= last_next;
            name_sel_reg  <= name_sel_next;
            if (cfg_write && (paddr[2] == ptwa_pkg::REG_STALE_LIMIT))
            begin
                limit_reg <= pwdata;
            end
        end
    end

    // entry memory: one read, one write per cycle, registered read data
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[ent_wa] <= ent_wd;
        end
        ent_rd_reg <= entry_mem[ent_ra];
    end

    // expired-name buffer, replayed after the scan so every report carries
    // the final entry count
    always_ff @(posedge clk)
    begin
        if (rb_we)
        begin
            rbuf_mem[rb_wa] <= ent_rd_reg.name;
        end
        rb_rd_reg <= rbuf_mem[rb_ra];
    end

    logic [NAME_W+127:0] name_wide;
    logic [CW+6:0]       count_wide;

    assign name_wide  = {128'd0, (name_sel_reg ? rb_rd_reg : {NAME_W{1'b0}})};
    assign count_wide = {7'd0, count_reg};

    assign busy          = (state_reg != ST_IDLE);
    assign result_valid  = out_valid_reg;
    assign kind          = kind_reg;
    assign is_new        = is_new_reg;
    assign table_full    = full_reg;
    assign out_name_low  = name_wide[63:0];
    assign out_name_high = name_wide[127:64];
    assign entry_count   = count_wide[6:0];
    assign last          = last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ptwa_pkg::REG_STALE_LIMIT) ? limit_reg : 32'd0;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above table depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXP_CHK) |-> (idx_reg <= count_reg))
        else $error("expire scan index ran past the entry count");

    a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DROP_MOVE) |-> (count_reg != '0))
        else $error("drop move on an empty table");

    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ((nres_reg != '0) && (idx_reg < nres_reg)))
        else $error("report replay outside the buffered range");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> ($past(state_next) == ST_IDLE))
        else $error("last result while the item is still in progress");
`endif

endmodule
